// ----- hw/rtl/mmwq_pkg.sv -----
// Shared types and constants for the mutex manager with wait queues.
package mmwq_pkg;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned ID_W     = 6;
  localparam int unsigned CALLER_W = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned WOKEN_W  = 16;
  localparam int unsigned SCAN_GRP = 8;

  localparam int unsigned NUM_MUTEXES_DEF    = 64;
  localparam int unsigned QUEUE_DEPTH_DEF    = 16;
  localparam int unsigned THREAD_ID_BITS_DEF = 16;

  typedef enum logic [MODE_W-1:0] {
    OP_ALLOC     = 3'd0,
    OP_DEALLOC   = 3'd1,
    OP_LOCK      = 3'd2,
    OP_UNLOCK    = 3'd3,
    OP_YIELDLOCK = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [ID_W-1:0]     granted;
    logic                blocked;
    logic                woken_valid;
    logic [WOKEN_W-1:0]  woken;
  } rsp_t;

  typedef struct packed {
    logic ptr_we;
    logic q_we;
  } qm_wen_t;

  typedef struct packed {
    logic done;
    logic found;
  } scan_sts_t;

endpackage

// ----- hw/rtl/mmwq_if.sv -----
// Request and response channel interfaces.
interface mmwq_req_if;
  import mmwq_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [ID_W-1:0]     lock_id;
  logic [ID_W-1:0]     second_lock_id;
  logic [CALLER_W-1:0] caller_thread;

  modport source (output valid, mode, lock_id, second_lock_id, caller_thread, input ready);
  modport sink   (input valid, mode, lock_id, second_lock_id, caller_thread, output ready);
endinterface

interface mmwq_rsp_if;
  import mmwq_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     granted_mutex;
  logic                caller_blocked;
  logic                woken_valid;
  logic [WOKEN_W-1:0]  woken_thread;

  modport source (output valid, status, granted_mutex, caller_blocked, woken_valid,
                  woken_thread, input ready);
  modport sink   (input valid, status, granted_mutex, caller_blocked, woken_valid,
                  woken_thread, output ready);
endinterface

// ----- hw/rtl/mmwq_qmem.sv -----
// Queue pointer memory and wait queue ring memory, both with registered reads.
module mmwq_qmem #(
  parameter int unsigned NUM_MUTEXES    = mmwq_pkg::NUM_MUTEXES_DEF,
  parameter int unsigned QUEUE_DEPTH    = mmwq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned THREAD_ID_BITS = mmwq_pkg::THREAD_ID_BITS_DEF
) (
  input  logic                                          clk_i,
  input  mmwq_pkg::qm_wen_t                             wen_i,
  input  logic [$clog2(NUM_MUTEXES)-1:0]                ptr_raddr_i,
  input  logic [$clog2(NUM_MUTEXES)-1:0]                ptr_waddr_i,
  input  logic [$clog2(QUEUE_DEPTH)-1:0]                ptr_whead_i,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]              ptr_wcnt_i,
  output logic [$clog2(QUEUE_DEPTH)-1:0]                ptr_rhead_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]              ptr_rcnt_o,
  input  logic [$clog2(NUM_MUTEXES*QUEUE_DEPTH)-1:0]    q_raddr_i,
  input  logic [$clog2(NUM_MUTEXES*QUEUE_DEPTH)-1:0]    q_waddr_i,
  input  logic [THREAD_ID_BITS-1:0]                     q_wdata_i,
  output logic [THREAD_ID_BITS-1:0]                     q_rdata_o
);

  localparam int unsigned HW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [HW+CW-1:0]          ptr_mem [NUM_MUTEXES];
  logic [THREAD_ID_BITS-1:0] q_mem   [NUM_MUTEXES*QUEUE_DEPTH];
  logic [HW+CW-1:0]          ptr_rd_q;
  logic [THREAD_ID_BITS-1:0] q_rd_q;

  always_ff @(posedge clk_i) begin
    if (wen_i.ptr_we) begin
      ptr_mem[ptr_waddr_i] <= {ptr_whead_i, ptr_wcnt_i};
    end
    ptr_rd_q <= ptr_mem[ptr_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wen_i.q_we) begin
      q_mem[q_waddr_i] <= q_wdata_i;
    end
    q_rd_q <= q_mem[q_raddr_i];
  end

  assign {ptr_rhead_o, ptr_rcnt_o} = ptr_rd_q;
  assign q_rdata_o = q_rd_q;

endmodule

// ----- hw/rtl/mmwq_scan.sv -----
// Lowest-free-slot search over the in-use flags, one group of slots per cycle.
module mmwq_scan #(
  parameter int unsigned NUM_MUTEXES = mmwq_pkg::NUM_MUTEXES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [NUM_MUTEXES-1:0]          in_use_i,
  output mmwq_pkg::scan_sts_t             sts_o,
  output logic [$clog2(NUM_MUTEXES)-1:0]  slot_o
);
  import mmwq_pkg::*;

  localparam int unsigned IW  = $clog2(NUM_MUTEXES);
  localparam int unsigned NG  = (NUM_MUTEXES + SCAN_GRP - 1) / SCAN_GRP;
  localparam int unsigned GCW = (NG > 1) ? $clog2(NG) : 1;
  localparam int unsigned PW  = $clog2(SCAN_GRP);

  logic                     busy_q, busy_d;
  logic [GCW-1:0]           grp_q, grp_d;
  logic [NG*SCAN_GRP-1:0]   pad;
  logic [SCAN_GRP-1:0]      free_bits;
  logic [PW-1:0]            pos;
  logic                     hit;
  logic                     last;

  always_comb begin
    pad = '1;
    pad[NUM_MUTEXES-1:0] = in_use_i;
    free_bits = ~pad[grp_q*SCAN_GRP +: SCAN_GRP];
    hit = |free_bits;
    pos = '0;
    for (int i = SCAN_GRP - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        pos = PW'(i);
      end
    end
    last = (32'(grp_q) == NG - 1);
  end

  assign sts_o.done  = busy_q && (hit || last);
  assign sts_o.found = busy_q && hit;
  assign slot_o      = IW'({grp_q, pos});

  always_comb begin
    busy_d = busy_q;
    grp_d  = grp_q;
    if (start_i) begin
      busy_d = 1'b1;
      grp_d  = '0;
    end else if (busy_q) begin
      if (hit || last) begin
        busy_d = 1'b0;
      end else begin
        grp_d = grp_q + GCW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      grp_q  <= '0;
    end else begin
      busy_q <= busy_d;
      grp_q  <= grp_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_found_is_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.found |-> !in_use_i[slot_o])
    else $error("scan reports a slot that is in use");

  a_miss_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts_o.done && !sts_o.found) |-> (&in_use_i))
    else $error("scan missed a free slot");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("scan started while busy");
`endif

endmodule

// ----- hw/rtl/mutex_manager_with_wait_queues_top.sv -----
// Mutex manager top: request sequencer, mutex flags, result register.
//
//   channel  dir  handshake        payload
//   req_i    in   valid / ready    mode, lock_id, second_lock_id, caller_thread
//   rsp_o    out  valid / ready    status, granted_mutex, caller_blocked,
//                                  woken_valid, woken_thread
//
// Request path: dealloc, lock and plain unlock finish in S_RD1; unlock handing
// off goes S_RD1, S_POP; yieldlock goes S_RD1, S_RD2, then finishes or goes to
// S_POP or S_YPOP; alloc searches in S_SCAN, a group of eight slots at a time.
// Memory reads are registered. If the result register is still full at the end,
// the sequencer waits in S_RSP until it drains, which takes longer while the sink stalls.
// Reset clears the in-use and locked flags at once; no memory clearing pass.
module mutex_manager_with_wait_queues_top #(
  parameter int unsigned NUM_MUTEXES    = mmwq_pkg::NUM_MUTEXES_DEF,
  parameter int unsigned QUEUE_DEPTH    = mmwq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned THREAD_ID_BITS = mmwq_pkg::THREAD_ID_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mmwq_req_if.sink   req_i,
  mmwq_rsp_if.source rsp_o
);
  import mmwq_pkg::*;

  localparam int unsigned IW = $clog2(NUM_MUTEXES);
  localparam int unsigned HW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW = $clog2(NUM_MUTEXES * QUEUE_DEPTH);
  localparam int unsigned TW = THREAD_ID_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_SCAN,
    S_POP,
    S_YPOP,
    S_RSP
  } state_e;

  function automatic logic [HW-1:0] ring_add(input logic [HW-1:0] h, input logic [CW-1:0] c);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(c);
    if (s >= (CW+1)'(QUEUE_DEPTH)) begin
      s = s - (CW+1)'(QUEUE_DEPTH);
    end
    return HW'(s);
  endfunction

  function automatic logic [AW-1:0] q_addr(input logic [IW-1:0] m, input logic [HW-1:0] p);
    return AW'(m) * AW'(QUEUE_DEPTH) + AW'(p);
  endfunction

  state_e                  state_q, state_d;
  logic [NUM_MUTEXES-1:0]  in_use_q, in_use_d;
  logic [NUM_MUTEXES-1:0]  locked_q, locked_d;
  logic [MODE_W-1:0]       mode_q;
  logic [ID_W-1:0]         id1_q, id2_q;
  logic [TW-1:0]           caller_q;
  logic [HW-1:0]           phead_q;
  logic [CW-1:0]           pcnt_q;
  rsp_t                    res, res_q, out_q, out_data;
  logic                    out_valid_q;
  logic                    out_free, out_load, fin, acc;
  logic                    ok1, ok2, l2, u1;
  logic [IW-1:0]           m1, m2;

  qm_wen_t                 wen;
  logic [IW-1:0]           ptr_raddr, ptr_waddr;
  logic [HW-1:0]           ptr_whead, ptr_rhead;
  logic [CW-1:0]           ptr_wcnt, ptr_rcnt;
  logic [AW-1:0]           q_raddr, q_waddr;
  logic [TW-1:0]           q_rdata;

  scan_sts_t               scan_sts;
  logic [IW-1:0]           scan_slot;
  logic                    scan_start;

  mmwq_qmem #(
    .NUM_MUTEXES    (NUM_MUTEXES),
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_qmem (
    .clk_i       (clk_i),
    .wen_i       (wen),
    .ptr_raddr_i (ptr_raddr),
    .ptr_waddr_i (ptr_waddr),
    .ptr_whead_i (ptr_whead),
    .ptr_wcnt_i  (ptr_wcnt),
    .ptr_rhead_o (ptr_rhead),
    .ptr_rcnt_o  (ptr_rcnt),
    .q_raddr_i   (q_raddr),
    .q_waddr_i   (q_waddr),
    .q_wdata_i   (caller_q),
    .q_rdata_o   (q_rdata)
  );

  mmwq_scan #(
    .NUM_MUTEXES (NUM_MUTEXES)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scan_start),
    .in_use_i (in_use_q),
    .sts_o    (scan_sts),
    .slot_o   (scan_slot)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign acc         = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign ok1 = (32'(id1_q) < NUM_MUTEXES);
  assign ok2 = (32'(id2_q) < NUM_MUTEXES);
  assign m1  = IW'(id1_q);
  assign m2  = IW'(id2_q);

  always_comb begin
    state_d    = state_q;
    in_use_d   = in_use_q;
    locked_d   = locked_q;
    fin        = 1'b0;
    res        = '0;
    wen        = '0;
    ptr_raddr  = m1;
    ptr_waddr  = m1;
    ptr_whead  = '0;
    ptr_wcnt   = '0;
    q_raddr    = '0;
    q_waddr    = '0;
    scan_start = 1'b0;
    l2         = 1'b0;
    u1         = 1'b0;

    case (state_q)
      S_IDLE: begin
        ptr_raddr = IW'(req_i.lock_id);
        if (req_i.valid) begin
          if (op_e'(req_i.mode) == OP_ALLOC) begin
            scan_start = 1'b1;
            state_d    = S_SCAN;
          end else begin
            state_d = S_RD1;
          end
        end
      end

      S_SCAN: begin
        if (scan_sts.done) begin
          fin = 1'b1;
          if (scan_sts.found) begin
            in_use_d[scan_slot] = 1'b1;
            locked_d[scan_slot] = 1'b0;
            wen.ptr_we  = 1'b1;
            ptr_waddr   = scan_slot;
            res.granted = ID_W'(scan_slot);
          end else begin
            res.status = ST_BAD;
          end
        end
      end

      S_RD1: begin
        ptr_raddr = m2;
        case (op_e'(mode_q))
          OP_DEALLOC: begin
            fin = 1'b1;
            if (ok1 && in_use_q[m1] && !locked_q[m1]) begin
              in_use_d[m1] = 1'b0;
            end else begin
              res.status = ST_BAD;
            end
          end
          OP_LOCK: begin
            fin = 1'b1;
            if (!ok1 || !in_use_q[m1]) begin
              res.status = ST_BAD;
            end else if (locked_q[m1]) begin
              if (ptr_rcnt >= CW'(QUEUE_DEPTH)) begin
                res.status = ST_FULL;
              end else begin
                wen.q_we    = 1'b1;
                q_waddr     = q_addr(m1, ring_add(ptr_rhead, ptr_rcnt));
                wen.ptr_we  = 1'b1;
                ptr_whead   = ptr_rhead;
                ptr_wcnt    = ptr_rcnt + CW'(1);
                res.blocked = 1'b1;
              end
            end else begin
              locked_d[m1] = 1'b1;
            end
          end
          OP_UNLOCK: begin
            if (!ok1 || !in_use_q[m1] || !locked_q[m1]) begin
              fin        = 1'b1;
              res.status = ST_BAD;
            end else if (ptr_rcnt != '0) begin
              q_raddr    = q_addr(m1, ptr_rhead);
              wen.ptr_we = 1'b1;
              ptr_whead  = ring_add(ptr_rhead, CW'(1));
              ptr_wcnt   = ptr_rcnt - CW'(1);
              state_d    = S_POP;
            end else begin
              fin          = 1'b1;
              locked_d[m1] = 1'b0;
            end
          end
          OP_YIELDLOCK: begin
            state_d = S_RD2;
          end
          default: begin
            fin        = 1'b1;
            res.status = ST_BAD;
          end
        endcase
      end

      S_RD2: begin
        // phead_q/pcnt_q hold mutex one, memory output holds mutex two
        if (!ok1 || !ok2 || !in_use_q[m1] || !locked_q[m1]) begin
          fin        = 1'b1;
          res.status = ST_BAD;
        end else if (in_use_q[m2] && ptr_rcnt != '0) begin
          q_raddr = q_addr(m2, ptr_rhead);
          state_d = S_YPOP;
        end else begin
          l2 = in_use_q[m2] && locked_q[m2];
          u1 = locked_q[m1] && !(l2 && (m1 == m2));
          if (l2) begin
            locked_d[m2] = 1'b0;
          end
          if (u1 && pcnt_q != '0) begin
            q_raddr    = q_addr(m1, phead_q);
            wen.ptr_we = 1'b1;
            ptr_whead  = ring_add(phead_q, CW'(1));
            ptr_wcnt   = pcnt_q - CW'(1);
            state_d    = S_POP;
          end else begin
            fin = 1'b1;
            if (u1) begin
              locked_d[m1] = 1'b0;
            end
          end
        end
      end

      S_POP: begin
        fin             = 1'b1;
        res.woken_valid = 1'b1;
        res.woken       = WOKEN_W'(q_rdata);
      end

      S_YPOP: begin
        fin             = 1'b1;
        wen.q_we        = 1'b1;
        q_waddr         = q_addr(m2, ring_add(phead_q, pcnt_q));
        wen.ptr_we      = 1'b1;
        ptr_waddr       = m2;
        ptr_whead       = ring_add(phead_q, CW'(1));
        ptr_wcnt        = pcnt_q;
        res.blocked     = 1'b1;
        res.woken_valid = 1'b1;
        res.woken       = WOKEN_W'(q_rdata);
      end

      S_RSP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      state_d = out_free ? S_IDLE : S_RSP;
    end
  end

  assign out_load = out_free && (fin || (state_q == S_RSP));
  assign out_data = (state_q == S_RSP) ? res_q : res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_use_q    <= '0;
      locked_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q  <= state_d;
      in_use_q <= in_use_d;
      locked_q <= locked_d;
      if (out_load) begin
        out_q       <= out_data;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      mode_q   <= req_i.mode;
      id1_q    <= req_i.lock_id;
      id2_q    <= req_i.second_lock_id;
      caller_q <= TW'(req_i.caller_thread);
    end
    if (state_q == S_RD1 || state_q == S_RD2) begin
      phead_q <= ptr_rhead;
      pcnt_q  <= ptr_rcnt;
    end
    if (fin) begin
      res_q <= res;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_q.status;
  assign rsp_o.granted_mutex  = out_q.granted;
  assign rsp_o.caller_blocked = out_q.blocked;
  assign rsp_o.woken_valid    = out_q.woken_valid;
  assign rsp_o.woken_thread   = out_q.woken;

`ifndef NO_ASSERTIONS
  a_locked_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (locked_q & ~in_use_q) == '0)
    else $error("locked flag set on a free mutex");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> !req_i.ready)
    else $error("request taken while sequencer busy");

  a_woken_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.woken_valid) |-> (out_q.status == ST_OK))
    else $error("handoff reported with failing status");

  a_scan_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (op_e'(mode_q) == OP_ALLOC))
    else $error("slot scan outside of alloc");
`endif

endmodule
